// File: design/source_text_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// source_text_tokenizer_macros
// Assertion macros for the tokenizer checker. They expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// Check a property that is ignored while reset is high.
`define STT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property that must also hold around reset.
`define STT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared constants and types for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int POSITION_BITS_DEFAULT = 24;
  localparam int FIELD_BITS            = 24;
  localparam int FIFO_DEPTH            = 4;

  localparam logic [3:0] KIND_EOF      = 4'd0;
  localparam logic [3:0] KIND_DOT      = 4'd1;
  localparam logic [3:0] KIND_COMMA    = 4'd2;
  localparam logic [3:0] KIND_COLON    = 4'd3;
  localparam logic [3:0] KIND_LPAREN   = 4'd4;
  localparam logic [3:0] KIND_RPAREN   = 4'd5;
  localparam logic [3:0] KIND_LBRACKET = 4'd6;
  localparam logic [3:0] KIND_RBRACKET = 4'd7;
  localparam logic [3:0] KIND_LBRACE   = 4'd8;
  localparam logic [3:0] KIND_RBRACE   = 4'd9;
  localparam logic [3:0] KIND_SPACE    = 4'd10;
  localparam logic [3:0] KIND_COMMENT  = 4'd11;
  localparam logic [3:0] KIND_WORD     = 4'd12;
  localparam logic [3:0] KIND_DIGITS   = 4'd13;
  localparam logic [3:0] KIND_OPER     = 4'd14;
  localparam logic [3:0] KIND_UNKNOWN  = 4'd15;

  typedef struct packed {
    logic [3:0]            kind;
    logic [FIELD_BITS-1:0] tbegin;
    logic [FIELD_BITS-1:0] tlength;
    logic                  last;
  } token_t;

  // Up to two tokens produced by one input beat, in order.
  typedef struct packed {
    logic [1:0] n;
    token_t     first;
    token_t     second;
  } push_t;

endpackage

// File: design/stt_byte_if.sv
// ----------------------------------------------------------------------------
// stt_byte_if
// Source text channel: one byte or an end marker per beat.
// ----------------------------------------------------------------------------
interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_marker;

  modport source (output valid, output text_byte, output end_marker, input ready);
  modport sink (input valid, input text_byte, input end_marker, output ready);
endinterface

// File: design/stt_token_if.sv
// ----------------------------------------------------------------------------
// stt_token_if
// Token channel: one token per beat.
// ----------------------------------------------------------------------------
interface stt_token_if;
  logic                              valid;
  logic                              ready;
  logic [3:0]                        token_kind;
  logic [stt_pkg::FIELD_BITS-1:0]    token_begin;
  logic [stt_pkg::FIELD_BITS-1:0]    token_size;
  logic                              last_of_item;

  modport source (output valid, output token_kind, output token_begin,
                  output token_size, output last_of_item, input ready);
  modport sink (input valid, input token_kind, input token_begin,
                input token_size, input last_of_item, output ready);
endinterface

// File: design/stt_scan.sv
// ----------------------------------------------------------------------------
// stt_scan
// Run state registers and the per-byte step; emits up to two tokens per beat.
// ----------------------------------------------------------------------------
module stt_scan #(
  parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          text_byte,
  input  logic                end_marker,
  output stt_pkg::push_t      push
);

  localparam logic [POSITION_BITS-1:0] POS_MAX  = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_ONE  = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] POS_ZERO = '0;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [5:0] {
    RUN_NONE    = 6'b000001,
    RUN_SPACE   = 6'b000010,
    RUN_COMMENT = 6'b000100,
    RUN_WORD    = 6'b001000,
    RUN_DIGIT   = 6'b010000,
    RUN_OPER    = 6'b100000
  } run_class_t;

  run_class_t               run_class, run_class_next;
  logic [POSITION_BITS-1:0] run_begin, run_begin_next;
  logic [POSITION_BITS-1:0] run_length, run_length_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return (c == CH_EQ) || (c == CH_BANG) || (c == CH_GT) || (c == CH_LT) ||
           (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  // KIND_EOF here means the byte is not single punctuation.
  function automatic logic [3:0] single_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      CH_DOT:   k = stt_pkg::KIND_DOT;
      CH_COMMA: k = stt_pkg::KIND_COMMA;
      CH_COLON: k = stt_pkg::KIND_COLON;
      CH_LPAR:  k = stt_pkg::KIND_LPAREN;
      CH_RPAR:  k = stt_pkg::KIND_RPAREN;
      CH_LBRK:  k = stt_pkg::KIND_LBRACKET;
      CH_RBRK:  k = stt_pkg::KIND_RBRACKET;
      CH_LBRC:  k = stt_pkg::KIND_LBRACE;
      CH_RBRC:  k = stt_pkg::KIND_RBRACE;
      default:  k = stt_pkg::KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] run_kind(input run_class_t cls);
    logic [3:0] k;
    case (cls)
      RUN_SPACE:   k = stt_pkg::KIND_SPACE;
      RUN_COMMENT: k = stt_pkg::KIND_COMMENT;
      RUN_WORD:    k = stt_pkg::KIND_WORD;
      RUN_DIGIT:   k = stt_pkg::KIND_DIGITS;
      RUN_OPER:    k = stt_pkg::KIND_OPER;
      default:     k = stt_pkg::KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic continues(input run_class_t cls, input logic [7:0] c);
    logic r;
    case (cls)
      RUN_SPACE: r = is_space(c);
      RUN_WORD:  r = is_word(c);
      RUN_DIGIT: r = is_digit(c);
      RUN_OPER:  r = is_oper(c);
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic stt_pkg::token_t mk_tok(input logic [3:0] kind,
                                             input logic [POSITION_BITS-1:0] b,
                                             input logic [POSITION_BITS-1:0] l,
                                             input logic last);
    stt_pkg::token_t t;
    t.kind    = kind;
    t.tbegin  = stt_pkg::FIELD_BITS'(b);
    t.tlength = stt_pkg::FIELD_BITS'(l);
    t.last    = last;
    return t;
  endfunction

  logic            pending;
  logic [3:0]      sk;
  logic            new_valid;
  stt_pkg::token_t run_tok;
  stt_pkg::token_t new_tok;

  always_comb begin
    run_class_next     = run_class;
    run_begin_next     = run_begin;
    run_length_next    = run_length;
    byte_position_next = byte_position;
    pending            = (run_class != RUN_NONE);
    sk                 = single_kind(text_byte);
    run_tok            = mk_tok(run_kind(run_class), run_begin, run_length, 1'b0);
    new_tok            = mk_tok(stt_pkg::KIND_UNKNOWN, byte_position, POS_ONE, 1'b1);
    new_valid          = 1'b0;
    push               = '0;

    if (accept) begin
      if (end_marker) begin
        // Flush the pending run, then EOF; clear everything.
        new_tok = mk_tok(stt_pkg::KIND_EOF, byte_position, POS_ONE, 1'b1);
        if (pending) begin
          push.n      = 2'd2;
          push.first  = run_tok;
          push.second = new_tok;
        end else begin
          push.n     = 2'd1;
          push.first = new_tok;
        end
        run_class_next     = RUN_NONE;
        run_begin_next     = POS_ZERO;
        run_length_next    = POS_ZERO;
        byte_position_next = POS_ZERO;
      end else if (run_class == RUN_COMMENT) begin
        if (text_byte == CH_HASH) begin
          run_tok.last    = 1'b1;
          push.n          = 2'd1;
          push.first      = run_tok;
          run_class_next  = RUN_NONE;
          run_begin_next  = POS_ZERO;
          run_length_next = POS_ZERO;
        end else begin
          run_length_next = sat_inc(run_length);
        end
        byte_position_next = sat_inc(byte_position);
      end else if (pending && continues(run_class, text_byte)) begin
        run_length_next    = sat_inc(run_length);
        byte_position_next = sat_inc(byte_position);
      end else begin
        // Break the pending run, then treat the byte as fresh.
        run_class_next  = RUN_NONE;
        run_begin_next  = POS_ZERO;
        run_length_next = POS_ZERO;
        if (sk != stt_pkg::KIND_EOF) begin
          new_valid    = 1'b1;
          new_tok.kind = sk;
        end else if (text_byte == CH_HASH) begin
          run_class_next = RUN_COMMENT;
          run_begin_next = sat_inc(byte_position);
        end else if (is_space(text_byte) || is_word(text_byte) ||
                     is_digit(text_byte) || is_oper(text_byte)) begin
          run_class_next  = is_space(text_byte) ? RUN_SPACE :
                            is_word(text_byte)  ? RUN_WORD  :
                            is_digit(text_byte) ? RUN_DIGIT : RUN_OPER;
          run_begin_next  = byte_position;
          run_length_next = POS_ONE;
        end else begin
          new_valid = 1'b1;
        end
        byte_position_next = sat_inc(byte_position);

        if (pending && new_valid) begin
          push.n      = 2'd2;
          push.first  = run_tok;
          push.second = new_tok;
        end else if (pending) begin
          run_tok.last = 1'b1;
          push.n       = 2'd1;
          push.first   = run_tok;
        end else if (new_valid) begin
          push.n     = 2'd1;
          push.first = new_tok;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_class     <= RUN_NONE;
      run_begin     <= POS_ZERO;
      run_length    <= POS_ZERO;
      byte_position <= POS_ZERO;
    end else begin
      run_class     <= run_class_next;
      run_begin     <= run_begin_next;
      run_length    <= run_length_next;
      byte_position <= byte_position_next;
    end
  end

endmodule

// File: design/stt_token_fifo.sv
// ----------------------------------------------------------------------------
// stt_token_fifo
// Small token queue: takes up to two tokens a cycle, hands out one.
// ----------------------------------------------------------------------------
module stt_token_fifo (
  input  logic            clk,
  input  logic            rst,
  input  stt_pkg::push_t  push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output stt_pkg::token_t out_tok
);

  localparam int DEPTH = stt_pkg::FIFO_DEPTH;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  stt_pkg::token_t mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr, wr_ptr_next;
  logic [IDX_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_tok   = mem[rd_ptr];
  // Hold input until two slots are free.
  assign room      = (count <= CNT_W'(DEPTH - 2));

  always_comb begin
    wr_ptr_next = IDX_W'(wr_ptr + IDX_W'(push.n));
    rd_ptr_next = IDX_W'(rd_ptr + IDX_W'(pop));
    count_next  = CNT_W'(count + CNT_W'(push.n) - CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem[IDX_W'(wr_ptr + 1'b1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

// File: design/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming tokenizer: source bytes in, (kind, begin, length) tokens out.
// ----------------------------------------------------------------------------
//   channel  | dir | payload
//   ---------+-----+---------------------------------------------------
//   text     | in  | text_byte[7:0], end_marker
//   tokens   | out | token_kind[3:0], token_begin[23:0],
//            |     | token_size[23:0], last_of_item
//
// One byte is taken per cycle; each beat yields zero, one or two tokens,
// which enter a four-entry token queue in the cycle the byte is taken.
// Tokens leave at one per cycle while tokens.ready is high, so bytes that
// break a run and emit a token (two tokens) throttle input to the token
// drain rate. Input is held off while fewer than two queue slots are free.
// Synchronous reset clears the run state, the position and the queue.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
  parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  stt_byte_if.sink      text,
  stt_token_if.source   tokens
);

  stt_pkg::push_t  push;
  stt_pkg::token_t out_tok;
  logic            room;
  logic            accept;

  assign text.ready = room;
  assign accept     = text.valid && room;

  stt_scan #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .text_byte  (text.text_byte),
    .end_marker (text.end_marker),
    .push       (push)
  );

  stt_token_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (tokens.valid),
    .out_ready (tokens.ready),
    .out_tok   (out_tok)
  );

  assign tokens.token_kind   = out_tok.kind;
  assign tokens.token_begin  = out_tok.tbegin;
  assign tokens.token_size   = out_tok.tlength;
  assign tokens.last_of_item = out_tok.last;

endmodule

// File: design/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the tokenizer output channel.
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_macros.svh"

module stt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  token_kind,
  input logic [23:0] token_size,
  input logic        last_of_item
);

  // Hold a stalled beat.
  `STT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "token beat dropped while stalled")
  `STT_ASSERT_RST(a_rst_empty, rst |=> !out_valid, "token valid right after reset")
  `STT_ASSERT(a_eof_shape, out_valid && token_kind == stt_pkg::KIND_EOF |-> last_of_item && token_size == 24'd1, "EOF token not final or not one byte")
  `STT_ASSERT(a_single_len, out_valid && ((token_kind >= stt_pkg::KIND_DOT && token_kind <= stt_pkg::KIND_RBRACE) || token_kind == stt_pkg::KIND_UNKNOWN) |-> token_size == 24'd1, "one-byte token with wrong length")

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (tokens.valid),
  .out_ready    (tokens.ready),
  .token_kind   (tokens.token_kind),
  .token_size   (tokens.token_size),
  .last_of_item (tokens.last_of_item)
);
